FILE: hw/rtl/drrip_pkg.sv
// Shared types and constants for the DRRIP dead-block replacement block.
// No dependencies; used by drrip_lfsr, drrip_row_logic and the top level.
package drrip_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned SETS_DEF    = 2048;
  localparam int unsigned WAYS_DEF    = 16;
  localparam int unsigned SEL_MAX_DEF = 1023;
  localparam int unsigned ODDS_DEF    = 32;

  // Request word
  typedef struct packed {
    logic        kind;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic        hit;
    logic [15:0] valid_mask;
  } in_t;

  // Result word
  typedef struct packed {
    logic [3:0] victim_way;
    logic       is_victim;
    logic [1:0] victim_reason;
  } out_t;

  // Request kinds
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Result reason codes
  localparam logic [1:0] RSN_INVALID = 2'd0;
  localparam logic [1:0] RSN_DEAD    = 2'd1;
  localparam logic [1:0] RSN_RRIP    = 2'd2;
  localparam logic [1:0] RSN_UPDATE  = 2'd3;

  // Config register indexes
  localparam logic CFG_LEADER = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  // Per-way counter values
  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_SRRIP = 2'd2;
  localparam logic [1:0] RRPV_HIT   = 2'd0;
  localparam logic [1:0] DEAD_MAX   = 2'd3;
  localparam logic [1:0] DEAD_RESET = 2'd1;

  // Register reset values
  localparam logic [10:0] LEADER_RESET = 11'd32;
  localparam logic [9:0]  THRESH_RESET = 10'd512;
  localparam int unsigned PSEL_RESET   = 512;

  // Bimodal LFSR
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'h0001;

endpackage

FILE: hw/rtl/drrip_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module drrip_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/drrip_lfsr.sv
// Bimodal insertion LFSR with a look-ahead check of the next value modulo the odds.
// Depends on drrip_pkg.
module drrip_lfsr #(
  parameter int unsigned BIMODAL_ODDS = drrip_pkg::ODDS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  output logic draw_low_o
);

  // Reciprocal for exact division of a 16-bit value by the odds
  localparam int unsigned SH    = 16 + $clog2(BIMODAL_ODDS);
  localparam int unsigned RECIP = (2 ** SH) / BIMODAL_ODDS + 1;
  localparam int unsigned RW    = SH + 1;
  localparam int unsigned PW    = 16 + RW;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ drrip_pkg::LFSR_MASK;
    end
    return r;
  endfunction

  logic [15:0] lfsr_q;
  logic [15:0] nxt;
  logic [15:0] nxt_q;
  logic [15:0] quot_q;
  logic        zero_q;
  logic [PW-1:0] prod;
  logic [23:0]   back;

  assign nxt  = lfsr_step(lfsr_q);
  assign prod = PW'(nxt) * PW'(RW'(RECIP));
  assign back = 24'(quot_q) * 24'(BIMODAL_ODDS);

  // State advances only on a bimodal draw
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= drrip_pkg::LFSR_SEED;
    end else if (advance_i) begin
      lfsr_q <= nxt;
    end
  end

  // Two-stage remainder check: quotient and next value are registered, then the compare
  always_ff @(posedge clk_i) begin
    nxt_q  <= nxt;
    quot_q <= 16'(prod >> SH);
    zero_q <= (back == 24'(nxt_q));
  end

  assign draw_low_o = zero_q;

endmodule

FILE: hw/rtl/drrip_row_logic.sv
// Victim choice and per-way counter update for one set row.
// Depends on drrip_pkg.
module drrip_row_logic #(
  parameter int unsigned WAYS = drrip_pkg::WAYS_DEF
) (
  input  logic [WAYS*4-1:0] row_i,
  input  drrip_pkg::in_t    item_i,
  input  logic [1:0]        ins_rrpv_i,
  output logic [WAYS*4-1:0] row_o,
  output drrip_pkg::out_t   res_o
);

  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  always_comb begin
    logic [1:0]    top;
    logic [1:0]    age;
    logic [1:0]    rr;
    logic [1:0]    dc;
    logic          f_inv;
    logic          f_dead;
    logic [WW-1:0] p_inv;
    logic [WW-1:0] p_dead;
    logic [WW-1:0] p_rrip;

    top    = '0;
    rr     = '0;
    dc     = '0;
    f_inv  = 1'b0;
    f_dead = 1'b0;
    p_inv  = '0;
    p_dead = '0;
    p_rrip = '0;
    row_o  = row_i;
    res_o  = '{victim_way: 4'd0, is_victim: 1'b0, victim_reason: drrip_pkg::RSN_UPDATE};

    // Highest RRPV in the set
    for (int w = 0; w < WAYS; w++) begin
      if (row_i[w*4 +: 2] > top) begin
        top = row_i[w*4 +: 2];
      end
    end
    age = drrip_pkg::RRPV_MAX - top;

    // Find-first searches, lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((w < 16) && !item_i.valid_mask[4'(w)]) begin
        f_inv = 1'b1;
        p_inv = WW'(w);
      end
      if (row_i[w*4+2 +: 2] == 2'd0) begin
        f_dead = 1'b1;
        p_dead = WW'(w);
      end
      if (row_i[w*4 +: 2] == top) begin
        p_rrip = WW'(w);
      end
    end

    if (item_i.kind == drrip_pkg::KIND_VICTIM) begin
      res_o.is_victim = 1'b1;
      if (f_inv) begin
        res_o.victim_way    = 4'(p_inv);
        res_o.victim_reason = drrip_pkg::RSN_INVALID;
      end else if (f_dead) begin
        res_o.victim_way    = 4'(p_dead);
        res_o.victim_reason = drrip_pkg::RSN_DEAD;
      end else begin
        res_o.victim_way    = 4'(p_rrip);
        res_o.victim_reason = drrip_pkg::RSN_RRIP;
        // Age the set so the oldest way sits at the max RRPV
        for (int w = 0; w < WAYS; w++) begin
          row_o[w*4 +: 2] = row_i[w*4 +: 2] + age;
        end
      end
    end else begin
      // Update of the addressed way; ways past the set size match nothing
      for (int w = 0; w < WAYS; w++) begin
        if (6'(w) == 6'(item_i.way)) begin
          rr = row_i[w*4 +: 2];
          dc = row_i[w*4+2 +: 2];
          if (item_i.hit) begin
            if (dc != drrip_pkg::DEAD_MAX) begin
              dc = dc + 2'd1;
            end
            rr = drrip_pkg::RRPV_HIT;
          end else begin
            if (dc != 2'd0) begin
              dc = dc - 2'd1;
            end
            rr = ins_rrpv_i;
          end
          row_o[w*4 +: 4] = {dc, rr};
        end
      end
    end
  end

endmodule

FILE: hw/rtl/drrip_dead_block_replacement_top.sv
// Top level of the DRRIP dead-block replacement policy: control sequencer,
// set-dueling selector and config registers. Depends on drrip_pkg, drrip_ram,
// drrip_lfsr and drrip_row_logic.
//
// One request passes through ST_RD, ST_CALC and ST_WR: the set row is read from
// the row RAM, the victim or update is computed, and the row is written back
// while the result is strobed for one cycle; the block then returns to ST_IDLE
// and takes the next request. busy stays high throughout and the receiver has
// no way to stall. A set index at or beyond SETS is first wrapped in ST_MOD by
// repeated subtraction of SETS. After reset the RAM is initialized by a sweep
// over all SETS rows, and every SETS*WAYS counted updates a decay sweep over
// every row lowers all dead counters by one, saturating at zero; busy is high during
// both. Config writes are taken at any time (cfg_ready_o is always high).
module drrip_dead_block_replacement_top #(
  parameter int unsigned SETS         = drrip_pkg::SETS_DEF,
  parameter int unsigned WAYS         = drrip_pkg::WAYS_DEF,
  parameter int unsigned SELECTOR_MAX = drrip_pkg::SEL_MAX_DEF,
  parameter int unsigned BIMODAL_ODDS = drrip_pkg::ODDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  drrip_pkg::in_t  in_item_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [10:0]     cfg_data_i,
  output logic            result_strobe_o,
  output drrip_pkg::out_t result_o
);

  localparam int unsigned ADDR_W = $clog2(SETS);
  localparam int unsigned RW     = WAYS * 4;
  localparam int unsigned SW     = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int unsigned PSEL_W = ($clog2(SELECTOR_MAX + 1) > 10) ?
                                   $clog2(SELECTOR_MAX + 1) : 10;
  localparam int unsigned TOTAL  = SETS * WAYS;
  localparam int unsigned CNT_W  = $clog2(TOTAL);
  localparam int unsigned PTR_W  = ADDR_W + 1;
  localparam logic [RW-1:0] CLEAR_ROW = {WAYS{drrip_pkg::DEAD_RESET, drrip_pkg::RRPV_MAX}};

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_RD, ST_CALC, ST_WR, ST_DECAY
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [ADDR_W-1:0] daddr_q, daddr_d;
  drrip_pkg::in_t   item_q, item_d;
  logic [SW-1:0]    set_q, set_d;
  logic [10:0]      leader_q, leader_d;
  logic [9:0]       thresh_q, thresh_d;
  logic [PSEL_W-1:0] psel_q, psel_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RW-1:0]    wr_row_q, wr_row_d;
  drrip_pkg::out_t  res_q, res_d;
  logic             eff_q, eff_d;
  logic             strobe_q, strobe_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [RW-1:0]     mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [RW-1:0]     mem_rdata;

  logic              draw_low;
  logic              lfsr_adv;
  logic [1:0]        ins_rrpv;
  logic [RW-1:0]     calc_row;
  drrip_pkg::out_t   calc_res;
  logic [RW-1:0]     decay_row;
  logic              srrip_lead;
  logic              brrip_lead;
  logic              use_brrip;
  logic              eff;

  drrip_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  drrip_lfsr #(.BIMODAL_ODDS(BIMODAL_ODDS)) u_lfsr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (lfsr_adv),
    .draw_low_o (draw_low)
  );

  drrip_row_logic #(.WAYS(WAYS)) u_row (
    .row_i      (mem_rdata),
    .item_i     (item_q),
    .ins_rrpv_i (ins_rrpv),
    .row_o      (calc_row),
    .res_o      (calc_res)
  );

  // Set dueling: leader ranges and follower policy
  assign srrip_lead = {1'b0, set_q} < (SW+1)'(leader_q);
  assign brrip_lead = !srrip_lead && ({1'b0, set_q} < (SW+1)'({leader_q, 1'b0}));
  assign use_brrip  = !srrip_lead && (brrip_lead || (psel_q >= PSEL_W'(thresh_q)));
  assign ins_rrpv   = (use_brrip && !draw_low) ? drrip_pkg::RRPV_MAX : drrip_pkg::RRPV_SRRIP;
  assign eff        = (item_q.kind == drrip_pkg::KIND_UPDATE) &&
                      (6'(item_q.way) < 6'(WAYS));

  // Dead counters one step lower, saturating
  always_comb begin
    decay_row = mem_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (mem_rdata[w*4+2 +: 2] != 2'd0) begin
        decay_row[w*4+2 +: 2] = mem_rdata[w*4+2 +: 2] - 2'd1;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    pend_d    = pend_q;
    daddr_d   = daddr_q;
    item_d    = item_q;
    set_d     = set_q;
    leader_d  = leader_q;
    thresh_d  = thresh_q;
    psel_d    = psel_q;
    cnt_d     = cnt_q;
    wr_row_d  = wr_row_q;
    res_d     = res_q;
    eff_d     = eff_q;
    strobe_d  = 1'b0;
    lfsr_adv  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = set_q[ADDR_W-1:0];
    mem_wdata = wr_row_q;
    mem_raddr = set_q[ADDR_W-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[ADDR_W-1:0];
        mem_wdata = CLEAR_ROW;
        if (ptr_q == PTR_W'(SETS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_d = in_item_i;
          set_d  = SW'(in_item_i.set_index);
          if ({1'b0, SW'(in_item_i.set_index)} >= (SW+1)'(SETS)) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_MOD: begin
        if ({1'b0, set_q} >= (SW+1)'(SETS)) begin
          set_d = set_q - SW'(SETS);
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        wr_row_d = calc_row;
        res_d    = calc_res;
        eff_d    = eff;
        strobe_d = 1'b1;
        state_d  = ST_WR;
        if (eff && !item_q.hit) begin
          lfsr_adv = use_brrip;
          if (srrip_lead) begin
            if (psel_q < PSEL_W'(SELECTOR_MAX)) begin
              psel_d = psel_q + PSEL_W'(1);
            end
          end else if (brrip_lead) begin
            if (psel_q != '0) begin
              psel_d = psel_q - PSEL_W'(1);
            end
          end
        end
      end
      ST_WR: begin
        mem_we  = (item_q.kind == drrip_pkg::KIND_VICTIM) || eff_q;
        state_d = ST_IDLE;
        if (eff_q) begin
          if (cnt_q == CNT_W'(TOTAL - 1)) begin
            cnt_d   = '0;
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_DECAY;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_DECAY: begin
        // Read row ptr while writing back the row read in the previous cycle
        mem_raddr = ptr_q[ADDR_W-1:0];
        mem_we    = pend_q;
        mem_waddr = daddr_q;
        mem_wdata = decay_row;
        daddr_d   = ptr_q[ADDR_W-1:0];
        pend_d    = ptr_q < PTR_W'(SETS);
        if (ptr_q < PTR_W'(SETS)) begin
          ptr_d = ptr_q + PTR_W'(1);
        end else if (!pend_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Config writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        drrip_pkg::CFG_LEADER: leader_d = cfg_data_i;
        drrip_pkg::CFG_THRESH: thresh_d = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      leader_q <= drrip_pkg::LEADER_RESET;
      thresh_q <= drrip_pkg::THRESH_RESET;
      psel_q   <= PSEL_W'(drrip_pkg::PSEL_RESET);
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      leader_q <= leader_d;
      thresh_q <= thresh_d;
      psel_q   <= psel_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    daddr_q  <= daddr_d;
    item_q   <= item_d;
    set_q    <= set_d;
    wr_row_q <= wr_row_d;
    res_q    <= res_d;
    eff_q    <= eff_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // An accepted request makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result word only follows the compute step
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == ST_CALC))
    else $error("result strobe outside write-back");

  // The row address is wrapped before the RAM is read
  a_set_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ({1'b0, set_q} < (SW+1)'(SETS)))
    else $error("set index not wrapped before read");

  // Victim answers never carry the update code
  a_victim_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.is_victim) |->
      (result_o.victim_reason != drrip_pkg::RSN_UPDATE))
    else $error("victim word with update reason");

endmodule
